// ----- rtl/core/csvm_pkg.sv -----
// Shared types and constants for the sparse matrix-vector multiply-accumulate core.
package csvm_pkg;

    // Field widths of the request and result payloads.
    localparam int INDEX_W = 10;
    localparam int VALUE_W = 32;
    localparam int FUNC_W  = 2;
    localparam int ROW_W   = 16;
    localparam int SUM_W   = 64;

    // Function codes carried on the input selector.
    localparam logic [FUNC_W-1:0] FUNC_LOAD    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_NONZERO = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_EMPTY   = 2'd2;

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Operation after classification.
    typedef enum logic [1:0] {
        OP_LOAD,
        OP_NONZERO,
        OP_EMPTY
    } op_t;

    // One classified request as it travels through the queue.
    typedef struct packed {
        op_t                       op;
        logic [INDEX_W-1:0]        index;
        logic signed [VALUE_W-1:0] value;
        logic                      last;
        logic                      in_range;
    } item_t;

endpackage

// ----- rtl/core/csr_sparse_matrix_vector_mac_core.sv -----
// Top level of the compressed-sparse-row matrix-vector multiply-accumulate core.
//
// The core takes one request per clock while its queue has room: a load writes a
// Q16.16 vector entry, a nonzero multiplies its Q16.16 value by the stored entry at
// its column and adds the Q32.32 product into a saturating row sum, and an
// empty-row request emits a zero sum. A nonzero marked with tlast closes its row
// and emits the row number with its sum. Requests pass through a four-entry queue
// into a three-stage back end (store read, multiply, accumulate into the result
// register); the accumulate loop sets the sustained rate of one request per cycle
// while the result side does not stall. Loads ahead of a nonzero are always seen by
// it. The vector store is not cleared at reset, so each entry must be loaded before
// a nonzero reads it.
module csr_sparse_matrix_vector_mac_core
    import csvm_pkg::*;
#(
    parameter int VECTOR_DEPTH = 1024,
    parameter int ROW_LIMIT    = 65536
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // entry_index[9:0], entry_value[41:10], zero fill
    input  logic [7:0]  s_tuser,   // func[1:0], zero fill
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata    // row_number[15:0], row_sum[79:16]
);

    logic             keep;
    item_t            front_item;
    logic             full;
    logic             pop_valid;
    logic             pop_ready;
    item_t            pop_item;
    logic [ROW_W-1:0] row_number;
    logic [SUM_W-1:0] row_sum;

    csvm_front #(
        .VECTOR_DEPTH(VECTOR_DEPTH)
    ) u_front (
        .func_i  (s_tuser[FUNC_W-1:0]),
        .index_i (s_tdata[INDEX_W-1:0]),
        .value_i (s_tdata[INDEX_W+VALUE_W-1:INDEX_W]),
        .last_i  (s_tlast),
        .keep_o  (keep),
        .item_o  (front_item)
    );

    // A request is taken whenever the queue has room.
    assign s_tready = !full;

    csvm_queue u_queue (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push_i      (s_tvalid && s_tready && keep),
        .push_item_i (front_item),
        .full_o      (full),
        .pop_valid_o (pop_valid),
        .pop_ready_i (pop_ready),
        .pop_item_o  (pop_item)
    );

    csvm_back #(
        .VECTOR_DEPTH(VECTOR_DEPTH),
        .ROW_LIMIT   (ROW_LIMIT)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .pop_valid_i (pop_valid),
        .pop_item_i  (pop_item),
        .pop_ready_o (pop_ready),
        .out_valid_o (m_tvalid),
        .out_ready_i (m_tready),
        .out_row_o   (row_number),
        .out_sum_o   (row_sum)
    );

    assign m_tdata = {row_sum, row_number};

endmodule

// ----- rtl/core/csvm_front.sv -----
// Front end: decodes each request, drops unused codes and checks the index range.
module csvm_front
    import csvm_pkg::*;
#(
    parameter int VECTOR_DEPTH = 1024
) (
    input  logic [FUNC_W-1:0]         func_i,
    input  logic [INDEX_W-1:0]        index_i,
    input  logic signed [VALUE_W-1:0] value_i,
    input  logic                      last_i,
    output logic                      keep_o,
    output item_t                     item_o
);

    // Classify the function code; an unused code is dropped here.
    always_comb begin
        keep_o         = 1'b1;
        item_o.op      = OP_LOAD;
        item_o.index   = index_i;
        item_o.value   = value_i;
        item_o.last    = last_i;
        item_o.in_range = (32'(index_i) < VECTOR_DEPTH);
        case (func_i)
            FUNC_LOAD: begin
                item_o.op = OP_LOAD;
                // A load beyond the store has no effect at all.
                keep_o = item_o.in_range;
            end
            FUNC_NONZERO: begin
                item_o.op = OP_NONZERO;
            end
            FUNC_EMPTY: begin
                item_o.op = OP_EMPTY;
            end
            default: begin
                keep_o = 1'b0;
            end
        endcase
    end

endmodule

// ----- rtl/core/csvm_queue.sv -----
// Short first-in first-out queue that decouples the front from the back.
module csvm_queue
    import csvm_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push_i,
    input  item_t push_item_i,
    output logic  full_o,
    output logic  pop_valid_o,
    input  logic  pop_ready_i,
    output item_t pop_item_o
);

    item_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               pop;

    assign full_o      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign pop_valid_o = (count_reg != '0);
    assign pop_item_o  = entry_reg[rd_ptr_reg];
    assign pop         = pop_valid_o && pop_ready_i;

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = push_i ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push_i && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push_i) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push_i) begin
            entry_reg[wr_ptr_reg] <= push_item_i;
        end
    end

endmodule

// ----- rtl/core/csvm_back.sv -----
// Back end: vector store, multiplier, saturating row accumulator and result register.
module csvm_back
    import csvm_pkg::*;
#(
    parameter int VECTOR_DEPTH = 1024,
    parameter int ROW_LIMIT    = 65536
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             pop_valid_i,
    input  item_t            pop_item_i,
    output logic             pop_ready_o,
    output logic             out_valid_o,
    input  logic             out_ready_i,
    output logic [ROW_W-1:0] out_row_o,
    output logic [SUM_W-1:0] out_sum_o
);

    localparam int AW = $clog2(VECTOR_DEPTH);
    localparam int CW = $clog2(ROW_LIMIT);

    logic [VALUE_W-1:0]        mem [VECTOR_DEPTH];
    logic [AW-1:0]             addr;
    logic                      adv;
    logic                      take;

    // Stage one: memory access.
    logic                      v1_reg;
    op_t                       op1_reg;
    logic                      last1_reg;
    logic                      range1_reg;
    logic signed [VALUE_W-1:0] value1_reg;
    logic signed [VALUE_W-1:0] rdata_reg;
    logic signed [VALUE_W-1:0] vec_value;

    // Stage two: product.
    logic                      v2_reg;
    op_t                       op2_reg;
    logic                      last2_reg;
    logic signed [SUM_W-1:0]   prod_reg;
    logic signed [SUM_W-1:0]   prod_next;

    // Row state and result register.
    logic [SUM_W-1:0]          acc_reg, acc_next;
    logic [CW-1:0]             cnt_reg, cnt_next, cnt_inc;
    logic [SUM_W-1:0]          sum;
    logic                      emit;
    logic [SUM_W-1:0]          sum_out;
    logic                      out_valid_reg;
    logic [ROW_W-1:0]          out_row_reg;
    logic [SUM_W-1:0]          out_sum_reg;

    // Signed add that clamps at the 64-bit limits.
    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
        logic [SUM_W-1:0] s;
        s = a + b;
        if ((a[SUM_W-1] == b[SUM_W-1]) && (s[SUM_W-1] != a[SUM_W-1])) begin
            s = a[SUM_W-1] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end
        return s;
    endfunction

    // The whole pipeline moves whenever the result register can take a result.
    assign adv         = !out_valid_reg || out_ready_i;
    assign pop_ready_o = adv;
    assign take        = adv && pop_valid_i;
    assign addr        = AW'(pop_item_i.index);

    // Vector store: loads write, nonzeros read with a registered read.
    always_ff @(posedge aclk) begin
        if (take && (pop_item_i.op == OP_LOAD) && pop_item_i.in_range) begin
            mem[addr] <= pop_item_i.value;
        end
        if (take && (pop_item_i.op == OP_NONZERO) && pop_item_i.in_range) begin
            rdata_reg <= mem[addr];
        end
    end

    // An index beyond the store reads as zero.
    assign vec_value = range1_reg ? rdata_reg : '0;
    assign prod_next = vec_value * value1_reg;

    // Accumulate, emit and advance the row counter.
    assign cnt_inc = ((32'(cnt_reg) + 32'd1) >= ROW_LIMIT) ? '0 : cnt_reg + 1'b1;
    assign sum     = sat_add(acc_reg, prod_reg);

    always_comb begin
        acc_next = acc_reg;
        cnt_next = cnt_reg;
        emit     = 1'b0;
        sum_out  = '0;
        if (v2_reg) begin
            case (op2_reg)
                OP_NONZERO: begin
                    if (last2_reg) begin
                        emit     = 1'b1;
                        sum_out  = sum;
                        acc_next = '0;
                        cnt_next = cnt_inc;
                    end else begin
                        acc_next = sum;
                    end
                end
                OP_EMPTY: begin
                    emit     = 1'b1;
                    cnt_next = cnt_inc;
                end
                default: begin
                end
            endcase
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
            cnt_reg       <= '0;
        end else if (adv) begin
            v1_reg        <= take && (pop_item_i.op != OP_LOAD);
            v2_reg        <= v1_reg;
            out_valid_reg <= emit;
            acc_reg       <= acc_next;
            cnt_reg       <= cnt_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (adv) begin
            op1_reg    <= pop_item_i.op;
            last1_reg  <= pop_item_i.last;
            range1_reg <= pop_item_i.in_range;
            value1_reg <= pop_item_i.value;
            op2_reg    <= op1_reg;
            last2_reg  <= last1_reg;
            prod_reg   <= prod_next;
            if (emit) begin
                out_row_reg <= ROW_W'(cnt_reg);
                out_sum_reg <= sum_out;
            end
        end
    end

    assign out_valid_o = out_valid_reg;
    assign out_row_o   = out_row_reg;
    assign out_sum_o   = out_sum_reg;

    // A closed row leaves the accumulator cleared.
    a_row_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && v2_reg && (op2_reg == OP_NONZERO) && last2_reg) |=> (acc_reg == '0))
        else $error("accumulator not cleared after row end");

    // The row counter stays below its wrap bound.
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        v2_reg |-> (32'(cnt_reg) < ROW_LIMIT))
        else $error("row counter beyond its bound");

    // A stalled back end keeps its row state.
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> ($stable(acc_reg) && $stable(cnt_reg) && $stable(v2_reg)))
        else $error("row state changed during a stall");

endmodule

// ----- dv/csr_sparse_matrix_vector_mac_core_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the CSR sparse matrix-vector multiply-accumulate core.
module csr_sparse_matrix_vector_mac_core_tb;
    import csvm_pkg::*;

    localparam int VECTOR_DEPTH    = 1024;
    localparam int ROW_LIMIT       = 65536;
    localparam int IDLE_PCT        = 37;
    localparam int RANDOM_REQUESTS = 1530;
    localparam int HOLD_CYCLES     = 120;
    localparam int DRAIN_CYCLES    = 20;

    // The one function code that the core ignores.
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    localparam logic signed [SUM_W-1:0]   SUM_MAX   = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0]   SUM_MIN   = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam logic signed [VALUE_W-1:0] Q16_ONE   = 32'sh0001_0000;

    // One completed row as the core should report it.
    typedef struct {
        logic [ROW_W-1:0]        row;
        logic signed [SUM_W-1:0] sum;
    } row_result_t;

    // Tracks the vector, the open row and the rows still owed by the core.
    class row_sum_scoreboard;
        logic signed [VALUE_W-1:0] vector_copy [VECTOR_DEPTH];
        logic signed [SUM_W-1:0]   row_acc;
        int unsigned               row_count;
        row_result_t               pending_rows[$];
        int                        errors;
        int                        rows_checked;
        int                        saturated_rows;

        function new();
            foreach (vector_copy[i]) vector_copy[i] = '0;
            row_acc        = '0;
            row_count      = 0;
            errors         = 0;
            rows_checked   = 0;
            saturated_rows = 0;
        endfunction

        task report(string msg);
            $display("[%0t] ERROR: %s", $time, msg);
            errors++;
        endtask

        // Signed add that clamps at the 64-bit limits.
        function logic signed [SUM_W-1:0] sat_add(logic signed [SUM_W-1:0] a,
                                                  logic signed [SUM_W-1:0] b);
            logic signed [SUM_W:0] wide;
            wide = {a[SUM_W-1], a} + {b[SUM_W-1], b};
            if (wide[SUM_W] != wide[SUM_W-1]) return wide[SUM_W] ? SUM_MIN : SUM_MAX;
            return wide[SUM_W-1:0];
        endfunction

        function void close_row(logic signed [SUM_W-1:0] sum);
            row_result_t r;
            r.row = row_count[ROW_W-1:0];
            r.sum = sum;
            pending_rows.push_back(r);
            row_count = (row_count + 1 >= ROW_LIMIT) ? 0 : row_count + 1;
        endfunction

        // Apply one accepted request to the predicted state.
        function void note_request(logic [FUNC_W-1:0] func, logic [INDEX_W-1:0] index,
                                   logic signed [VALUE_W-1:0] value, logic last);
            logic signed [VALUE_W-1:0] entry;
            logic signed [SUM_W-1:0]   product;
            case (func)
                FUNC_LOAD: begin
                    if (index < VECTOR_DEPTH) vector_copy[index] = value;
                end
                FUNC_NONZERO: begin
                    entry   = (index < VECTOR_DEPTH) ? vector_copy[index] : '0;
                    product = $signed({{(SUM_W-VALUE_W){value[VALUE_W-1]}}, value}) *
                              $signed({{(SUM_W-VALUE_W){entry[VALUE_W-1]}}, entry});
                    row_acc = sat_add(row_acc, product);
                    if (last) begin
                        close_row(row_acc);
                        row_acc = '0;
                    end
                end
                FUNC_EMPTY: begin
                    close_row('0);
                end
                default: begin
                end
            endcase
        endfunction

        // Compare one accepted result with the oldest row owed.
        task check_result(logic [ROW_W-1:0] row, logic signed [SUM_W-1:0] sum);
            row_result_t exp_row;
            if (pending_rows.size() == 0) begin
                report($sformatf("result with no row pending: row %0d sum %0d", row, sum));
                return;
            end
            exp_row = pending_rows.pop_front();
            rows_checked++;
            if (exp_row.sum == SUM_MAX || exp_row.sum == SUM_MIN) saturated_rows++;
            if (row !== exp_row.row)
                report($sformatf("row number %0d, expected %0d", row, exp_row.row));
            if (sum !== exp_row.sum)
                report($sformatf("row %0d sum %0d, expected %0d", exp_row.row, sum,
                                 exp_row.sum));
        endtask
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // entry_index[9:0], entry_value[41:10], zero fill
    logic [7:0]  s_tuser;   // func[1:0], zero fill
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;   // row_number[15:0], row_sum[79:16]

    row_sum_scoreboard  sb;
    bit                 steady_phase;
    int                 requests_taken;
    bit                 loaded [VECTOR_DEPTH];
    logic [INDEX_W-1:0] loaded_cols[$];

    csr_sparse_matrix_vector_mac_core #(
        .VECTOR_DEPTH(VECTOR_DEPTH),
        .ROW_LIMIT   (ROW_LIMIT)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Feed every accepted request to the predictor.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            sb.note_request(s_tuser[FUNC_W-1:0], s_tdata[INDEX_W-1:0],
                            s_tdata[INDEX_W+VALUE_W-1:INDEX_W], s_tlast);
            requests_taken++;
        end
    end

    // Check every accepted result.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata[ROW_W-1:0], m_tdata[ROW_W+SUM_W-1:ROW_W]);
    end

    // Result side: random stalls, none in the steady window, and one long hold-off.
    initial begin : result_sink
        int  stall_left;
        bit  held;
        m_tready   = 1'b0;
        stall_left = 0;
        held       = 1'b0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            if (!held && requests_taken >= 400) begin
                held       = 1'b1;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else if (steady_phase) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(99) >= IDLE_PCT);
            end
            @(posedge aclk);
        end
    end

    initial begin
        #2_000_000;
        $display("Timeout: %0d rows still pending", sb.pending_rows.size());
        $display("csr_sparse_matrix_vector_mac_core_tb NOT OK");
        $finish;
    end

    // Offer one request, with random idle cycles first outside the steady window, and wait until it is taken.
    task automatic send_request(logic [FUNC_W-1:0] func, logic [INDEX_W-1:0] index,
                                logic signed [VALUE_W-1:0] value, logic last);
        while (!steady_phase && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {{(8-FUNC_W){1'b0}}, func};
        s_tdata  <= {{(48-INDEX_W-VALUE_W){1'b0}}, value, index};
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // A load also records the column so later nonzeros only read written entries.
    task automatic send_load(logic [INDEX_W-1:0] index, logic signed [VALUE_W-1:0] value,
                             logic last);
        if (!loaded[index]) begin
            loaded[index] = 1'b1;
            loaded_cols.push_back(index);
        end
        send_request(FUNC_LOAD, index, value, last);
    endtask

    function automatic logic [INDEX_W-1:0] pick_column();
        return loaded_cols[$urandom_range(loaded_cols.size() - 1)];
    endfunction

    // Mix of full-range, small, whole-number and extreme Q16.16 values.
    function automatic logic signed [VALUE_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(9);
        if (sel < 4) return $urandom;
        if (sel < 7) return $urandom_range(2097152) - 1048576;
        if (sel < 9) return ($urandom_range(16) - 8) * 65536;
        case ($urandom_range(4))
            0:       return VALUE_MAX;
            1:       return VALUE_MIN;
            2:       return '0;
            3:       return 1;
            default: return -1;
        endcase
    endfunction

    initial begin
        int sent;
        int kind;
        int row_len;
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = '0;
        s_tlast        = 1'b0;
        steady_phase   = 1'b0;
        requests_taken = 0;
        sb             = new();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: extreme vector entries at both ends of the store.
        send_load(0, VALUE_MAX, 1'b0);
        send_load(INDEX_W'(VECTOR_DEPTH - 1), VALUE_MIN, 1'b0);
        send_load(1, Q16_ONE, 1'b0);
        send_load(2, -1, 1'b0);
        send_request(FUNC_NONZERO, 1, Q16_ONE, 1'b1);
        send_request(FUNC_NONZERO, 2, VALUE_MAX, 1'b1);
        // An empty row carrying the row-last mark, which it ignores.
        send_request(FUNC_EMPTY, 0, '0, 1'b1);
        // Largest positive products overflow and clamp at the top.
        for (int k = 0; k < 4; k++)
            send_request(FUNC_NONZERO, INDEX_W'(VECTOR_DEPTH - 1), VALUE_MIN, k == 3);
        // Largest negative products clamp at the bottom.
        for (int k = 0; k < 4; k++)
            send_request(FUNC_NONZERO, 0, VALUE_MIN, k == 3);
        // A load with the row-last mark, then an unused code that must do nothing.
        send_load(2, 5, 1'b1);
        send_request(FUNC_UNUSED, INDEX_W'(VECTOR_DEPTH - 1), -1, 1'b1);
        // An empty row in the middle of an open row leaves the partial sum alone.
        send_request(FUNC_NONZERO, 2, 3, 1'b0);
        send_request(FUNC_EMPTY, 0, '0, 1'b0);
        send_request(FUNC_NONZERO, 2, 1, 1'b1);
        send_request(FUNC_NONZERO, 0, VALUE_MAX, 1'b1);
        send_request(FUNC_NONZERO, 1, '0, 1'b1);

        // Random: mostly well-formed rows over loaded columns, with load bursts and noise.
        sent = 0;
        while (sent < RANDOM_REQUESTS) begin
            steady_phase = (sent >= 700 && sent < 950);
            kind = $urandom_range(99);
            if (kind < 15) begin
                repeat ($urandom_range(16, 1)) begin
                    send_load(INDEX_W'($urandom_range(VECTOR_DEPTH - 1)), pick_value(),
                              1'($urandom_range(1)));
                    sent++;
                end
            end else if (kind < 82) begin
                row_len = $urandom_range(8, 1);
                for (int k = 0; k < row_len; k++) begin
                    if ($urandom_range(49) == 0) begin
                        send_request(FUNC_EMPTY, INDEX_W'($urandom_range(VECTOR_DEPTH - 1)),
                                     $urandom, 1'b0);
                        sent++;
                    end
                    send_request(FUNC_NONZERO, pick_column(), pick_value(), k == row_len - 1);
                    sent++;
                end
            end else if (kind < 94) begin
                send_request(FUNC_EMPTY, INDEX_W'($urandom_range(VECTOR_DEPTH - 1)), $urandom,
                             1'($urandom_range(1)));
                sent++;
            end else begin
                send_request(FUNC_UNUSED, INDEX_W'($urandom_range(VECTOR_DEPTH - 1)), $urandom,
                             1'($urandom_range(1)));
            end
        end
        steady_phase = 1'b0;
        s_tvalid <= 1'b0;

        // Drain: wait for every owed row, then keep watching for stray results.
        while (sb.pending_rows.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d requests over %0d loaded columns; checked %0d rows, %0d saturated.",
                 requests_taken, loaded_cols.size(), sb.rows_checked, sb.saturated_rows);
        if (sb.errors == 0) begin
            $display("csr_sparse_matrix_vector_mac_core_tb OK");
        end else begin
            $display("csr_sparse_matrix_vector_mac_core_tb NOT OK");
        end
        $finish;
    end

endmodule
